// File: hw/rtl/ppa_pkg.sv
// ppa_pkg: shared types and constants for the position-to-acceleration controller
// holds the payload structs, register indexes, axis codes and fixed-point limits
// no dependencies
package ppa_pkg;

    // axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam int unsigned NUM_AXES = 3;

    // register map
    typedef enum logic [2:0] {
        REG_PROP_GAIN_XY   = 3'd0,
        REG_DAMP_GAIN_XY   = 3'd1,
        REG_INTEG_GAIN_XY  = 3'd2,
        REG_PROP_GAIN_Z    = 3'd3,
        REG_DAMP_GAIN_Z    = 3'd4,
        REG_INTEG_GAIN_Z   = 3'd5,
        REG_INTEG_LIMIT    = 3'd6,
        REG_ACCEL_XY_LIMIT = 3'd7
    } reg_index_t;

    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned DATA_W  = 32;

    // register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_XY_RST   = 24'd65536;
    localparam logic [GAIN_W-1:0]  DAMP_GAIN_XY_RST   = 24'd131072;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_XY_RST  = 24'd1311;
    localparam logic [GAIN_W-1:0]  PROP_GAIN_Z_RST    = 24'd212337;
    localparam logic [GAIN_W-1:0]  DAMP_GAIN_Z_RST    = 24'd259523;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_Z_RST   = 24'd9830;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST    = 31'd655360;
    localparam logic [LIMIT_W-1:0] ACCEL_XY_LIMIT_RST = 31'd131072;

    // gravity and z command bounds, Q16.16
    localparam int GRAVITY_Q16 = 642908;
    localparam int ACC_Z_MIN   = GRAVITY_Q16 * 3 / 10;
    localparam int ACC_Z_MAX   = GRAVITY_Q16 * 2;

    // internal arithmetic widths
    localparam int unsigned ERR_W   = DATA_W + 1;          // difference of two Q16.16
    localparam int unsigned ISUM_W  = ERR_W + 1;           // integrator plus error
    localparam int unsigned PROD_W  = GAIN_W + 1 + ERR_W;  // gain times error
    localparam int unsigned PQ_W    = PROD_W - 16;         // after floor shift
    localparam int unsigned IPROD_W = GAIN_W + 1 + DATA_W; // gain times integrator
    localparam int unsigned IQ_W    = IPROD_W - 16;
    localparam int unsigned PDS_W   = PQ_W + 2;            // p + d + ff + gravity
    localparam int unsigned TOT_W   = PDS_W + 1;

    typedef struct packed {
        logic [1:0]               axis;
        logic signed [DATA_W-1:0] target_pos;
        logic signed [DATA_W-1:0] measured_pos;
        logic signed [DATA_W-1:0] target_vel;
        logic signed [DATA_W-1:0] measured_vel;
        logic signed [DATA_W-1:0] ff_accel;
    } in_t;

    typedef struct packed {
        logic [1:0]               axis_out;
        logic signed [DATA_W-1:0] accel_cmd;
    } out_t;

endpackage

// File: hw/rtl/pid_position_to_accel_core.sv
// pid_position_to_accel_core: three-axis PID position controller with integrator clamp
// single module; integrator state lives in a small synchronous memory
// depends on ppa_pkg

// One axis transaction is accepted per clock unless the result channel stalls; its
// acceleration command passes through the stage 2, stage 3 and output registers. The
// rate is set by the single read-modify-write of the integrator memory in stage one,
// where the last write is forwarded to a following transaction on the same axis.
// Integrator entries read as zero until first written after reset (per-entry written
// flags), so no clearing pass is needed. Configuration writes are always accepted and
// must only be issued while no transaction is in flight. Axis code three yields a
// zero command and leaves all integrators untouched.
module pid_position_to_accel_core
    import ppa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_payload,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_payload,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]  prop_gain_xy_reg, damp_gain_xy_reg, integ_gain_xy_reg;
    logic [GAIN_W-1:0]  prop_gain_z_reg, damp_gain_z_reg, integ_gain_z_reg;
    logic [LIMIT_W-1:0] integ_limit_reg, accel_xy_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_xy_reg   <= PROP_GAIN_XY_RST;
            damp_gain_xy_reg   <= DAMP_GAIN_XY_RST;
            integ_gain_xy_reg  <= INTEG_GAIN_XY_RST;
            prop_gain_z_reg    <= PROP_GAIN_Z_RST;
            damp_gain_z_reg    <= DAMP_GAIN_Z_RST;
            integ_gain_z_reg   <= INTEG_GAIN_Z_RST;
            integ_limit_reg    <= INTEG_LIMIT_RST;
            accel_xy_limit_reg <= ACCEL_XY_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_PROP_GAIN_XY:   prop_gain_xy_reg   <= cfg_data[GAIN_W-1:0];
                REG_DAMP_GAIN_XY:   damp_gain_xy_reg   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN_XY:  integ_gain_xy_reg  <= cfg_data[GAIN_W-1:0];
                REG_PROP_GAIN_Z:    prop_gain_z_reg    <= cfg_data[GAIN_W-1:0];
                REG_DAMP_GAIN_Z:    damp_gain_z_reg    <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN_Z:   integ_gain_z_reg   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT:    integ_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_ACCEL_XY_LIMIT: accel_xy_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage moves when the one after it is empty or moving
    logic s1_valid_reg, s2_valid_reg;
    logic ready1, ready2, ready_out;
    logic in_acc, s1_move, s2_move;

    assign ready_out = !m_valid || m_ready;
    assign ready2    = !s2_valid_reg || ready_out;
    assign ready1    = !s1_valid_reg || ready2;
    assign s_ready   = ready1;
    assign in_acc    = s_valid && s_ready;
    assign s1_move   = s1_valid_reg && ready2;
    assign s2_move   = s2_valid_reg && ready_out;

    // integrator memory, one entry per axis
    logic signed [DATA_W-1:0] integ_mem [NUM_AXES];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [NUM_AXES-1:0]      written_reg;
    logic                     wb_valid_reg;
    logic [1:0]               wb_addr_reg;
    logic signed [DATA_W-1:0] wb_data_reg;
    logic                     mem_we;
    logic signed [DATA_W-1:0] integ_new;

    // stage 1 input register
    in_t s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ready1) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_reg <= s_payload;
        end
    end

    // memory read at accept, write back when stage 1 hands off
    always_ff @(posedge aclk) begin
        if (in_acc && (s_payload.axis != AXIS_NONE)) begin
            rd_data_reg <= integ_mem[s_payload.axis];
        end
        if (mem_we) begin
            integ_mem[s1_reg.axis] <= integ_new;
        end
    end

    // written flags and last-write record for forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            wb_valid_reg <= 1'b0;
        end else if (mem_we) begin
            written_reg[s1_reg.axis] <= 1'b1;
            wb_valid_reg             <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wb_addr_reg <= s1_reg.axis;
            wb_data_reg <= integ_new;
        end
    end

    // stage 1: errors, integrator update, proportional and damping products
    logic signed [ERR_W-1:0]  pos_err, vel_err;
    logic signed [DATA_W-1:0] integ_old;
    logic signed [ISUM_W-1:0] integ_sum, lim_hi, lim_lo;
    logic                     s1_is_z;
    logic [GAIN_W-1:0]        kp_sel, kd_sel;
    logic signed [PROD_W-1:0] p_full, d_full;

    assign s1_is_z = (s1_reg.axis == AXIS_Z);
    assign mem_we  = s1_move && (s1_reg.axis != AXIS_NONE);

    always_comb begin
        pos_err = ERR_W'(s1_reg.target_pos) - ERR_W'(s1_reg.measured_pos);
        vel_err = ERR_W'(s1_reg.target_vel) - ERR_W'(s1_reg.measured_vel);

        // pick the newest integrator value
        priority if (wb_valid_reg && (wb_addr_reg == s1_reg.axis)) begin
            integ_old = wb_data_reg;
        end else if ((s1_reg.axis != AXIS_NONE) && written_reg[s1_reg.axis]) begin
            integ_old = rd_data_reg;
        end else begin
            integ_old = '0;
        end

        // add and clamp at full width
        integ_sum = ISUM_W'(integ_old) + ISUM_W'(pos_err);
        lim_hi    = ISUM_W'({1'b0, integ_limit_reg});
        lim_lo    = -lim_hi;
        priority if (integ_sum >= lim_hi) begin
            integ_new = DATA_W'(lim_hi);
        end else if (integ_sum < lim_lo) begin
            integ_new = DATA_W'(lim_lo);
        end else begin
            integ_new = DATA_W'(integ_sum);
        end

        kp_sel = s1_is_z ? prop_gain_z_reg : prop_gain_xy_reg;
        kd_sel = s1_is_z ? damp_gain_z_reg : damp_gain_xy_reg;
        p_full = PROD_W'($signed({1'b0, kp_sel})) * PROD_W'(pos_err);
        d_full = PROD_W'($signed({1'b0, kd_sel})) * PROD_W'(vel_err);
    end

    // stage 2 registers
    logic [1:0]               s2_axis_reg;
    logic signed [DATA_W-1:0] s2_integ_reg, s2_ff_reg;
    logic signed [PQ_W-1:0]   s2_p_reg, s2_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ready2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_axis_reg  <= s1_reg.axis;
            s2_integ_reg <= integ_new;
            s2_ff_reg    <= s1_reg.ff_accel;
            s2_p_reg     <= p_full[PROD_W-1:16];
            s2_d_reg     <= d_full[PROD_W-1:16];
        end
    end

    // stage 2: integral product and partial sum
    logic                      s2_is_z;
    logic [GAIN_W-1:0]         ki_sel;
    logic signed [IPROD_W-1:0] i_full;
    logic signed [PDS_W-1:0]   pd_sum;

    always_comb begin
        s2_is_z = (s2_axis_reg == AXIS_Z);
        ki_sel  = s2_is_z ? integ_gain_z_reg : integ_gain_xy_reg;
        i_full  = IPROD_W'($signed({1'b0, ki_sel})) * IPROD_W'(s2_integ_reg);
        pd_sum  = PDS_W'(s2_p_reg) + PDS_W'(s2_d_reg) + PDS_W'(s2_ff_reg)
                + (s2_is_z ? PDS_W'(GRAVITY_Q16) : PDS_W'(0));
    end

    // stage 3 registers
    logic                     s3_valid_reg;
    logic [1:0]               s3_axis_reg;
    logic signed [IQ_W-1:0]   s3_i_reg;
    logic signed [PDS_W-1:0]  s3_pd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (ready_out) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            s3_axis_reg <= s2_axis_reg;
            s3_i_reg    <= i_full[IPROD_W-1:16];
            s3_pd_reg   <= pd_sum;
        end
    end

    // stage 3: final sum and clamp
    logic signed [TOT_W-1:0]  total, cmd_hi, cmd_lo;
    logic signed [DATA_W-1:0] cmd_clamped;

    always_comb begin
        total = TOT_W'(s3_pd_reg) + TOT_W'(s3_i_reg);
        if (s3_axis_reg == AXIS_Z) begin
            cmd_hi = TOT_W'(ACC_Z_MAX);
            cmd_lo = TOT_W'(ACC_Z_MIN);
        end else begin
            cmd_hi = TOT_W'({1'b0, accel_xy_limit_reg});
            cmd_lo = -TOT_W'({1'b0, accel_xy_limit_reg});
        end
        priority if (s3_axis_reg == AXIS_NONE) begin
            cmd_clamped = '0;
        end else if (total >= cmd_hi) begin
            cmd_clamped = DATA_W'(cmd_hi);
        end else if (total < cmd_lo) begin
            cmd_clamped = DATA_W'(cmd_lo);
        end else begin
            cmd_clamped = DATA_W'(total);
        end
    end

    // output register
    out_t m_payload_reg;
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_out) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && s3_valid_reg) begin
            m_payload_reg.axis_out  <= s3_axis_reg;
            m_payload_reg.accel_cmd <= cmd_clamped;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
